>>> hw/rtl/gha_pkg.sv
// Shared types and constants for the generational handle allocator.
`timescale 1ns / 1ps

package gha_pkg;

    // Default sizing of the slot pool.
    localparam int NUM_SLOTS_DEF = 64;
    localparam int GEN_BITS_DEF  = 16;

    // Fixed field widths of the words on the ports.
    localparam int OP_W   = 2;
    localparam int SLOT_W = 6;
    localparam int TAG_W  = 16;
    localparam int STAT_W = 2;

    // Operation codes. The fourth code is unused and reports an invalid handle.
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CHECK   = 2'd2
    } t_op;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // Control states of the allocator.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Input word.
    typedef struct packed {
        t_op               operation;
        logic [SLOT_W-1:0] slot_index;
        logic [TAG_W-1:0]  generation_tag;
    } t_in_word;

    // Output word.
    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] granted_slot;
        logic [TAG_W-1:0]  granted_generation;
    } t_out_word;

endpackage

>>> hw/rtl/generational_handle_allocator.sv
// Top level of the generational handle allocator.
`timescale 1ns / 1ps

// Hands out (slot, generation) handles from a pool of NUM_SLOTS slots, takes
// them back and checks them. The slot table and free stack are read when a
// word is accepted; in the execute state the result is formed, the slot table
// is written on a grant or release and the free stack on a release. No new
// word is taken while one is in work. A finished result waits in the output
// register; the block holds its execute state only while that register is
// full and stalled. Released slots are reused first, fresh ones in order once
// the stack is empty; no memory needs clearing after reset, as an entry is
// only used once an allocation or release wrote it. The stack keeps each
// released slot with its generation: a reuse bumps it without a second read.
module generational_handle_allocator import gha_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int GEN_BITS  = GEN_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;
    localparam int GW = (GEN_BITS > TAG_W) ? GEN_BITS : TAG_W;

    typedef struct packed {
        logic                active;
        logic [GEN_BITS-1:0] gen;
    } t_slot_entry;

    typedef struct packed {
        logic [GEN_BITS-1:0] gen;
        logic [IW-1:0]       slot;
    } t_stack_entry;

    // Control and bookkeeping registers.
    t_state            r_state, n_state;
    t_op               r_op;
    logic [SLOT_W-1:0] r_idx;
    logic [TAG_W-1:0]  r_tag;
    logic [CW-1:0]     r_free_count, n_free_count;
    logic [CW-1:0]     r_slots_used, n_slots_used;
    logic              r_out_valid;
    t_out_word         r_out_word;

    // Memory ports.
    logic          in_acc;
    logic          go;
    logic [XW-1:0] in_idx_x;
    logic [XW-1:0] r_idx_x;
    logic [CW-1:0] stk_top;
    t_slot_entry   slot_rd, slot_wdata;
    t_stack_entry  stk_rd, stk_wdata;
    logic          slot_we, stk_we;
    logic [IW-1:0] slot_waddr;
    t_out_word     res;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign in_idx_x = XW'(i_in_word.slot_index);
    assign r_idx_x  = XW'(r_idx);
    assign stk_top  = r_free_count - CW'(1);

    // Slot table: active bit and generation per slot.
    gha_ram #(
        .WIDTH ($bits(t_slot_entry)),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (in_acc),
        .i_raddr (in_idx_x[IW-1:0]),
        .o_rdata (slot_rd)
    );

    // Free stack: released slots with the generation they had.
    gha_ram #(
        .WIDTH ($bits(t_stack_entry)),
        .DEPTH (NUM_SLOTS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_free_count[IW-1:0]),
        .i_wdata (stk_wdata),
        .i_re    (in_acc),
        .i_raddr (stk_top[IW-1:0]),
        .o_rdata (stk_rd)
    );

    // Next state, result and write-back.
    always_comb begin
        logic [GEN_BITS-1:0] new_gen;
        logic [IW-1:0]       new_slot;
        logic [GW-1:0]       gen_x;
        logic [XW-1:0]       slot_x;
        logic                hit;

        n_state      = r_state;
        n_free_count = r_free_count;
        n_slots_used = r_slots_used;
        go           = 1'b0;
        slot_we      = 1'b0;
        stk_we       = 1'b0;
        slot_waddr   = r_idx_x[IW-1:0];
        slot_wdata   = '{active: 1'b0, gen: slot_rd.gen};
        stk_wdata    = '{gen: slot_rd.gen, slot: r_idx_x[IW-1:0]};
        new_gen      = '0;
        new_slot     = '0;
        gen_x        = GW'(slot_rd.gen);
        slot_x       = '0;
        hit          = (r_idx_x < XW'(r_slots_used)) && slot_rd.active
                       && (gen_x == GW'(r_tag));
        res          = '{status: ST_INVALID, granted_slot: '0, granted_generation: '0};

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                go = !r_out_valid || !i_out_stall;
                case (r_op)
                    OP_ALLOC: begin
                        if (r_free_count != '0) begin
                            new_slot     = stk_rd.slot;
                            new_gen      = stk_rd.gen + GEN_BITS'(1);
                            n_free_count = stk_top;
                            res.status   = ST_OK;
                        end else if (r_slots_used < CW'(NUM_SLOTS)) begin
                            new_slot     = r_slots_used[IW-1:0];
                            new_gen      = '0;
                            n_slots_used = r_slots_used + CW'(1);
                            res.status   = ST_OK;
                        end else begin
                            res.status   = ST_FULL;
                        end
                        if (res.status == ST_OK) begin
                            slot_we                = go;
                            slot_waddr             = new_slot;
                            slot_wdata             = '{active: 1'b1, gen: new_gen};
                            slot_x                 = XW'(new_slot);
                            gen_x                  = GW'(new_gen);
                            res.granted_slot       = slot_x[SLOT_W-1:0];
                            res.granted_generation = gen_x[TAG_W-1:0];
                        end
                    end
                    OP_RELEASE: begin
                        if (hit && (r_free_count < CW'(NUM_SLOTS))) begin
                            slot_we      = go;
                            stk_we       = go;
                            n_free_count = r_free_count + CW'(1);
                            res.status   = ST_OK;
                        end
                    end
                    OP_CHECK: begin
                        if (hit) begin
                            res.status = ST_OK;
                        end
                    end
                    default: begin
                        res.status = ST_INVALID;
                    end
                endcase
                if (go) begin
                    n_state = S_IDLE;
                end else begin
                    n_free_count = r_free_count;
                    n_slots_used = r_slots_used;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_count <= '0;
            r_slots_used <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_count <= n_free_count;
            r_slots_used <= n_slots_used;
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Captured input word and output word.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op  <= i_in_word.operation;
            r_idx <= i_in_word.slot_index;
            r_tag <= i_in_word.generation_tag;
        end
        if (go) begin
            r_out_word <= res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

>>> hw/rtl/gha_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/gha_checker.sv
// Port-level checker for the generational handle allocator, bound to the top level.
`timescale 1ns / 1ps

module gha_checker import gha_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // A failed operation carries no slot and no generation.
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status != ST_OK)
        |-> (o_out_word.granted_slot == '0) && (o_out_word.granted_generation == '0))
        else $error("grant fields set on a failed operation");

    // One word is in work at a time: an accepted word blocks the next cycle.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken while one is in work");

    // An accepted word passes the execute state, then its result is registered.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !(o_out_valid && i_out_stall) |=> ##1 o_out_valid)
        else $error("accepted word gave no result");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
